[src/point_in_polygon_test_core_macros.svh]
// Assertion macros shared by the point-in-polygon core.
`ifndef POINT_IN_POLYGON_TEST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_TEST_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PPT_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PPT_ASSERT_IMPLIES(label, ante, cons)
`define PPT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/ppt_pkg.sv]
`default_nettype none

package ppt_pkg;

	localparam int MAX_VERTICES_DEFAULT = 64;
	localparam int COORD_W = 32;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TEST = 1'b1;

	localparam logic [APB_ADDR_W-1:0] REG_VERTEX_COUNT = 2'd0;

	typedef struct packed {
		logic wr_en;
		logic load_test;
		logic rd_en;
		logic rd_first;
		logic load_res;
	} ppt_cmd_t;

endpackage

`default_nettype wire

[src/point_in_polygon_test_core.sv]
// Vertex write: no result; the next word is taken in the following cycle.
// Point test over n = min(vertex_count, MAX_VERTICES) vertices, one edge per cycle through
// the vertex memory read port and a subtract/multiply/compare pipe: the result is valid
// after the walk, drain and finish states (finish only when n is 0), the next word after that.
// A finished test holds input off while an earlier result still waits for out_ready.
// arst_n clears control state and vertex_count; vertex memory is undefined until written.
`default_nettype none

module point_in_polygon_test_core #(
	parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 kind,
	input  wire logic [ppt_pkg::INDEX_W-1:0]          vertex_index,
	input  wire logic signed [ppt_pkg::COORD_W-1:0]   x_value,
	input  wire logic signed [ppt_pkg::COORD_W-1:0]   y_value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      inside_res,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [ppt_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire logic [ppt_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [ppt_pkg::APB_DATA_W-1:0]            prdata,
	output logic                                      pready
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	logic [ppt_pkg::COUNT_W-1:0] vertex_count_q;
	ppt_pkg::ppt_cmd_t           cmd;
	logic [AW-1:0]               rd_addr;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && paddr == ppt_pkg::REG_VERTEX_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_wr) begin
			vertex_count_q <= pwdata[ppt_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ppt_pkg::REG_VERTEX_COUNT) begin
			prdata = ppt_pkg::APB_DATA_W'(vertex_count_q);
		end
	end

	ppt_controller #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.vertex_count(vertex_count_q),
		.cmd         (cmd),
		.rd_addr     (rd_addr)
	);

	ppt_datapath #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.vertex_index(vertex_index),
		.x_value     (x_value),
		.y_value     (y_value),
		.inside_res  (inside_res)
	);

endmodule

`default_nettype wire

[src/ppt_datapath.sv]
`default_nettype none

module ppt_datapath #(
	parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEFAULT,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ppt_pkg::ppt_cmd_t                 cmd,
	input  wire logic [AW-1:0]                     rd_addr,
	input  wire logic [ppt_pkg::INDEX_W-1:0]       vertex_index,
	input  wire logic signed [ppt_pkg::COORD_W-1:0] x_value,
	input  wire logic signed [ppt_pkg::COORD_W-1:0] y_value,
	output logic                                   inside_res
);

	localparam int CW = ppt_pkg::COORD_W;

	logic [CW-1:0] mem_x [MAX_VERTICES];
	logic [CW-1:0] mem_y [MAX_VERTICES];

	logic          slot_ok;
	logic [AW-1:0] wr_addr;

	logic signed [CW-1:0] tx_q, ty_q;
	logic signed [CW-1:0] px_q, py_q;

	logic                 v_s1, first_s1;
	logic signed [CW-1:0] xi_s1, yi_s1;

	logic                 e_s2, straddle_s2, dypos_s2;
	logic signed [CW:0]   dxi_s2, dy_s2, dx_s2, dty_s2;

	logic                   e_s3, straddle_s3, dypos_s3;
	logic signed [2*CW+1:0] pl_s3, pr_s3;

	logic inside_q;
	logic hit;

	assign slot_ok = int'(vertex_index) < MAX_VERTICES;
	assign wr_addr = AW'(vertex_index);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && slot_ok) begin
			mem_x[wr_addr] <= x_value;
			mem_y[wr_addr] <= y_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			xi_s1 <= mem_x[rd_addr];
			yi_s1 <= mem_y[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_test) begin
			tx_q <= x_value;
			ty_q <= y_value;
		end
		if (v_s1) begin
			px_q <= xi_s1;
			py_q <= yi_s1;
		end
		dxi_s2      <= {tx_q[CW-1], tx_q} - {xi_s1[CW-1], xi_s1};
		dy_s2       <= {py_q[CW-1], py_q} - {yi_s1[CW-1], yi_s1};
		dx_s2       <= {px_q[CW-1], px_q} - {xi_s1[CW-1], xi_s1};
		dty_s2      <= {ty_q[CW-1], ty_q} - {yi_s1[CW-1], yi_s1};
		straddle_s2 <= (yi_s1 > ty_q) != (py_q > ty_q);
		dypos_s2    <= py_q > yi_s1;
		pl_s3       <= dxi_s2 * dy_s2;
		pr_s3       <= dx_s2 * dty_s2;
		straddle_s3 <= straddle_s2;
		dypos_s3    <= dypos_s2;
		if (cmd.load_res) begin
			inside_res <= inside_q;
		end
	end

	assign hit = dypos_s3 ? (pl_s3 < pr_s3) : (pr_s3 < pl_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			e_s2     <= 1'b0;
			e_s3     <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			v_s1     <= cmd.rd_en;
			first_s1 <= cmd.rd_first;
			e_s2     <= v_s1 && !first_s1;
			e_s3     <= e_s2;
			if (cmd.load_test) begin
				inside_q <= 1'b0;
			end else if (e_s3 && straddle_s3 && hit) begin
				inside_q <= !inside_q;
			end
		end
	end

endmodule

`default_nettype wire

[src/ppt_controller.sv]
`default_nettype none
`include "point_in_polygon_test_core_macros.svh"

module ppt_controller #(
	parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEFAULT,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
	localparam int LW = $clog2(MAX_VERTICES + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        kind,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	input  wire logic [ppt_pkg::COUNT_W-1:0] vertex_count,
	output ppt_pkg::ppt_cmd_t                cmd,
	output logic [AW-1:0]                    rd_addr
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_FINISH
	} state_t;

	localparam logic [1:0] DRAIN_LAST = 2'd2;

	state_t        state_q;
	logic [LW-1:0] n_q, idx_q, n_sat;
	logic          seed_q;
	logic [1:0]    drain_q;
	logic          out_valid_q;
	logic          accept, out_free;

	assign n_sat = (int'(vertex_count) > MAX_VERTICES) ? LW'(MAX_VERTICES) : LW'(vertex_count);

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.wr_en     = accept && kind == ppt_pkg::KIND_VERTEX;
		cmd.load_test = accept && kind == ppt_pkg::KIND_TEST;
		cmd.rd_en     = state_q == S_WALK;
		cmd.rd_first  = state_q == S_WALK && seed_q;
		cmd.load_res  = state_q == S_FINISH && out_free;
		rd_addr       = seed_q ? AW'(n_q - LW'(1)) : AW'(idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			idx_q       <= '0;
			seed_q      <= 1'b0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.load_test) begin
						n_q    <= n_sat;
						idx_q  <= '0;
						seed_q <= 1'b1;
						state_q <= (n_sat == '0) ? S_FINISH : S_WALK;
					end
				end
				S_WALK: begin
					if (seed_q) begin
						seed_q <= 1'b0;
					end else begin
						idx_q <= idx_q + LW'(1);
						if (idx_q == n_q - LW'(1)) begin
							drain_q <= '0;
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == DRAIN_LAST) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PPT_ASSERT_IMPLIES(a_rd_in_range, cmd.rd_en, LW'(rd_addr) < n_q)
	`PPT_ASSERT_IMPLIES(a_load_res_free, cmd.load_res, !out_valid_q || out_ready)
	`PPT_ASSERT_NEXT(a_test_blocks, in_valid && in_ready && kind == ppt_pkg::KIND_TEST, !in_ready)
	`PPT_ASSERT_IMPLIES(a_idle_quiet, in_ready, !cmd.rd_en && !cmd.load_res)

endmodule

`default_nettype wire

[test/tb_point_in_polygon_test_core.sv]
`default_nettype none

module tb_point_in_polygon_test_core;

	localparam int MAX_V = ppt_pkg::MAX_VERTICES_DEFAULT;
	localparam logic signed [ppt_pkg::COORD_W-1:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [ppt_pkg::COORD_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [ppt_pkg::COORD_W-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLDOFF_CYCLES = 400;

	typedef struct {
		logic                               kind;
		logic [ppt_pkg::INDEX_W-1:0]        slot;
		logic signed [ppt_pkg::COORD_W-1:0] x;
		logic signed [ppt_pkg::COORD_W-1:0] y;
	} ppt_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = ppt_pkg::KIND_VERTEX;
	logic [ppt_pkg::INDEX_W-1:0] vertex_index = '0;
	logic signed [ppt_pkg::COORD_W-1:0] x_value = '0;
	logic signed [ppt_pkg::COORD_W-1:0] y_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic inside_res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ppt_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [ppt_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [ppt_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	point_in_polygon_test_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .vertex_index(vertex_index), .x_value(x_value), .y_value(y_value),
		.out_valid(out_valid), .out_ready(out_ready), .inside_res(inside_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ppt_word_t pending_words[$];
	bit inside_expected[$];
	logic signed [ppt_pkg::COORD_W-1:0] poly_x[MAX_V];
	logic signed [ppt_pkg::COORD_W-1:0] poly_y[MAX_V];
	logic [ppt_pkg::COUNT_W-1:0] vertex_limit = '0;
	int words_sent = 0;
	int words_taken = 0;
	int errors = 0;
	bit idle_on = 1'b1;
	int holdoff_req = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int results_seen = 0;
	ppt_word_t next_word;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_error(input string what);
		errors++;
		$display("ERROR t=%0t %s", $time, what);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// even-odd crossing test, exact cross-multiplication at 68 bits
	function automatic bit point_inside(input logic signed [ppt_pkg::COORD_W-1:0] tx,
			input logic signed [ppt_pkg::COORD_W-1:0] ty);
		int n, i, j;
		longint xi, yi, xj, yj, px, py;
		logic signed [67:0] a, b, c, d, lhs, rhs;
		bit flag, hit;
		flag = 1'b0;
		n = (vertex_limit > MAX_V) ? MAX_V : int'(vertex_limit);
		j = (n > 0) ? n - 1 : 0;
		px = tx;
		py = ty;
		for (i = 0; i < n; i++) begin
			xi = poly_x[i];
			yi = poly_y[i];
			xj = poly_x[j];
			yj = poly_y[j];
			if ((yi > py) != (yj > py)) begin
				a = px - xi;
				b = yj - yi;
				c = xj - xi;
				d = py - yi;
				lhs = a * b;
				rhs = c * d;
				hit = (yj - yi > 0) ? (lhs < rhs) : (lhs > rhs);
				if (hit)
					flag = !flag;
			end
			j = i;
		end
		return flag;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (inside_expected.size() == 0)
				flag_error($sformatf("result %0d with no test pending", inside_res));
			else if (inside_res !== inside_expected[0]) begin
				flag_error($sformatf("inside_res got %b want %b",
						inside_res, inside_expected[0]));
				void'(inside_expected.pop_front());
			end else
				void'(inside_expected.pop_front());
		end
		if (arst_n && in_valid && in_ready) begin
			words_taken++;
			if (kind == ppt_pkg::KIND_TEST)
				inside_expected.push_back(point_inside(x_value, y_value));
			else if (int'(vertex_index) < MAX_V) begin
				poly_x[vertex_index] = x_value;
				poly_y[vertex_index] = y_value;
			end
		end
	end

	always @(negedge clk) begin
		if (words_sent != words_taken) begin
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (pending_words.size() > 0) begin
			next_word = pending_words.pop_front();
			kind <= next_word.kind;
			vertex_index <= next_word.slot;
			x_value <= next_word.x;
			y_value <= next_word.y;
			in_valid <= 1'b1;
			words_sent++;
			if (idle_on)
				send_gap = pick_gap();
		end else
			in_valid <= 1'b0;
	end

	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			out_ready <= 1'b0;
			holdoff_left--;
		end else if (holdoff_req != holdoff_seen) begin
			holdoff_seen = holdoff_req;
			holdoff_left = HOLDOFF_CYCLES;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap--;
		end else begin
			out_ready <= 1'b1;
			if (idle_on)
				recv_gap = pick_gap();
		end
	end

	task automatic push_vertex(input int slot, input logic signed [ppt_pkg::COORD_W-1:0] x,
			input logic signed [ppt_pkg::COORD_W-1:0] y);
		ppt_word_t w;
		w.kind = ppt_pkg::KIND_VERTEX;
		w.slot = slot[ppt_pkg::INDEX_W-1:0];
		w.x = x;
		w.y = y;
		pending_words.push_back(w);
	endtask

	task automatic push_test(input logic signed [ppt_pkg::COORD_W-1:0] x,
			input logic signed [ppt_pkg::COORD_W-1:0] y);
		ppt_word_t w;
		w.kind = ppt_pkg::KIND_TEST;
		w.slot = ppt_pkg::INDEX_W'($urandom());
		w.x = x;
		w.y = y;
		pending_words.push_back(w);
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || words_sent != words_taken
				|| inside_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [ppt_pkg::APB_DATA_W-1:0] wdata,
			output logic [ppt_pkg::APB_DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ppt_pkg::REG_VERTEX_COUNT;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_vertex_count(input int value);
		logic [ppt_pkg::APB_DATA_W-1:0] rd;
		wait_drained();
		apb_access(1'b1, ppt_pkg::APB_DATA_W'(value), rd);
		vertex_limit = ppt_pkg::COUNT_W'(value);
		apb_access(1'b0, '0, rd);
		if (rd !== ppt_pkg::APB_DATA_W'(vertex_limit))
			flag_error($sformatf("vertex_count read %h want %h", rd, vertex_limit));
	endtask

	function automatic logic signed [ppt_pkg::COORD_W-1:0] pick_coord(input longint center,
			input longint span, input bit grid);
		if (grid)
			return ppt_pkg::COORD_W'(center
					+ (longint'($urandom_range(0, 8)) - 4) * (span / 4));
		return ppt_pkg::COORD_W'(center + longint'($urandom_range(0, 32'(2 * span))) - span);
	endfunction

	initial begin
		int ph, k, count, used, r;
		longint cx, cy, span;
		bit grid;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no vertices in use, then one and two vertices
		push_test('0, '0);
		push_test(Q_MAX, Q_MIN);
		for (k = 0; k < MAX_V; k++)
			push_vertex(k, ppt_pkg::COORD_W'($urandom()), ppt_pkg::COORD_W'($urandom()));
		set_vertex_count(1);
		push_test(ppt_pkg::COORD_W'($urandom()), ppt_pkg::COORD_W'($urandom()));
		set_vertex_count(2);
		push_test(ppt_pkg::COORD_W'($urandom()), ppt_pkg::COORD_W'($urandom()));

		// square of half-side one, points inside, outside, on edges and corners
		push_vertex(0, -Q_ONE, -Q_ONE);
		push_vertex(1, Q_ONE, -Q_ONE);
		push_vertex(2, Q_ONE, Q_ONE);
		push_vertex(3, -Q_ONE, Q_ONE);
		set_vertex_count(4);
		push_test('0, '0);
		push_test(2 * Q_ONE, '0);
		push_test(-Q_ONE, '0);
		push_test(Q_ONE, '0);
		push_test(Q_ONE, Q_ONE);
		push_test('0, -Q_ONE);
		push_test(Q_MIN, '0);
		push_test(Q_MAX, '0);

		// triangle spanning the full coordinate range
		push_vertex(0, Q_MIN, Q_MIN);
		push_vertex(1, Q_MAX, Q_MIN);
		push_vertex(2, '0, Q_MAX);
		set_vertex_count(3);
		push_test('0, '0);
		push_test(Q_MIN, '0);
		push_test(Q_MAX, Q_MAX);
		push_test(-1, Q_MIN + 1);

		for (ph = 0; ph < 14; ph++) begin
			r = $urandom_range(9);
			if (ph == 0)
				count = 127;
			else if (ph == 1)
				count = MAX_V;
			else if (r == 0)
				count = $urandom_range(0, 2);
			else if (r == 1)
				count = MAX_V;
			else if (r == 2)
				count = $urandom_range(MAX_V + 1, 127);
			else
				count = $urandom_range(3, 20);
			used = (count > MAX_V) ? MAX_V : count;
			cx = longint'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
			cy = longint'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
			span = longint'(1) << $urandom_range(4, 30);
			grid = ($urandom_range(3) == 0);
			idle_on = (ph % 4 != 1);
			set_vertex_count(count);
			for (k = 0; k < used; k++)
				push_vertex(k, pick_coord(cx, span, grid), pick_coord(cy, span, grid));
			if (ph == 3)
				holdoff_req++;
			for (k = 0; k < 18; k++) begin
				r = $urandom_range(99);
				if (r < 6)
					push_vertex($urandom_range(0, MAX_V - 1),
							ppt_pkg::COORD_W'($urandom()),
							ppt_pkg::COORD_W'($urandom()));
				else if (r < 15)
					push_vertex($urandom_range(0, MAX_V - 1), pick_coord(cx, span, grid),
							pick_coord(cy, span, grid));
				else if (r < 20)
					push_test(ppt_pkg::COORD_W'($urandom()),
							ppt_pkg::COORD_W'($urandom()));
				else
					push_test(pick_coord(cx, span + span / 4, grid),
							pick_coord(cy, span + span / 4, grid));
			end
		end

		idle_on = 1'b1;
		wait_drained();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
